@@ rtl/sa_pkg.sv @@
// Shared types for the self-attention head: command word that crosses the
// queue between front and back, opcode and matrix codes. No dependencies.
`default_nettype none
package sa_pkg;

	localparam int WADDR_W = 7;  // (3*8) rows x 4 columns at most

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_TOKEN  = 1'b1;

	localparam logic [1:0] MAT_QUERY = 2'd0;
	localparam logic [1:0] MAT_KEY   = 2'd1;
	localparam logic [1:0] MAT_VALUE = 2'd2;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_TOKEN = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [WADDR_W-1:0]  waddr;
		logic [15:0]         wval;
		logic [3:0][15:0]    tok;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/sa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 36
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/sa_front.sv @@
// Front end: accepts input transactions, checks weight addresses and builds
// the command word for the queue. Depends on sa_pkg.
`default_nettype none
module sa_front #(
	parameter int MODEL_DIM = 4,
	parameter int KEY_DIM   = 3,
	parameter int VALUE_DIM = 3
) (
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               op,
	input  wire logic [1:0]         weight_matrix,
	input  wire logic [2:0]         weight_row,
	input  wire logic [1:0]         weight_col,
	input  wire logic signed [15:0] weight_value,
	input  wire logic signed [15:0] token_elem_0,
	input  wire logic signed [15:0] token_elem_1,
	input  wire logic signed [15:0] token_elem_2,
	input  wire logic signed [15:0] token_elem_3,
	output logic                    push_valid,
	input  wire logic               push_stall,
	output sa_pkg::cmd_t            push_cmd
);
	import sa_pkg::*;

	logic [4:0] row_abs;
	logic       row_ok;
	logic       col_ok;

	always_comb begin
		row_ok  = 1'b0;
		row_abs = '0;
		case (weight_matrix)
			MAT_QUERY: begin
				row_ok  = {1'b0, weight_row} < 4'(KEY_DIM);
				row_abs = 5'(weight_row);
			end
			MAT_KEY: begin
				row_ok  = {1'b0, weight_row} < 4'(KEY_DIM);
				row_abs = 5'(KEY_DIM) + 5'(weight_row);
			end
			MAT_VALUE: begin
				row_ok  = {1'b0, weight_row} < 4'(VALUE_DIM);
				row_abs = 5'(2 * KEY_DIM) + 5'(weight_row);
			end
			default: begin
				row_ok  = 1'b0;
				row_abs = '0;
			end
		endcase
	end

	assign col_ok = {1'b0, weight_col} < 3'(MODEL_DIM);

	// bad weight addresses are accepted and dropped here
	assign item_stall = push_stall;
	assign push_valid = item_valid && ((op == OP_TOKEN) || (row_ok && col_ok));

	always_comb begin
		push_cmd.kind   = (op == OP_TOKEN) ? CMD_TOKEN : CMD_WRITE;
		push_cmd.waddr  = WADDR_W'(row_abs) * WADDR_W'(MODEL_DIM) + WADDR_W'(weight_col);
		push_cmd.wval   = weight_value;
		push_cmd.tok[0] = token_elem_0;
		push_cmd.tok[1] = token_elem_1;
		push_cmd.tok[2] = token_elem_2;
		push_cmd.tok[3] = token_elem_3;
	end
endmodule
`default_nettype wire

@@ rtl/sa_queue.sv @@
// Two-entry command queue between front end and engine.
// Depends on sa_pkg.
`default_nettype none
module sa_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_stall,
	input  wire sa_pkg::cmd_t  push_cmd,
	output logic               pop_valid,
	input  wire logic          pop_stall,
	output sa_pkg::cmd_t       pop_cmd
);
	import sa_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_stall = (cnt_q == 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sa_engine.sv @@
// Back end: weight RAM, projection / score / output MAC pipeline, softmax
// with exp table and bit-serial divider, result register.
// Depends on sa_pkg and sa_ram.
`default_nettype none
module sa_engine #(
	parameter int SEQ_LEN         = 4,
	parameter int MODEL_DIM       = 4,
	parameter int KEY_DIM         = 3,
	parameter int VALUE_DIM       = 3,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire sa_pkg::cmd_t  cmd,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [1:0]         query_index,
	output logic [15:0]        weight_0,
	output logic [15:0]        weight_1,
	output logic [15:0]        weight_2,
	output logic [15:0]        weight_3,
	output logic signed [15:0] result_0,
	output logic signed [15:0] result_1,
	output logic signed [15:0] result_2,
	output logic               last
);
	import sa_pkg::*;

	localparam int NROWS  = 2 * KEY_DIM + VALUE_DIM;
	localparam int NW     = NROWS * MODEL_DIM;
	localparam int RAW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int SW     = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
	localparam int KW     = (KEY_DIM > 1) ? $clog2(KEY_DIM) : 1;
	localparam int VW     = (VALUE_DIM > 1) ? $clog2(VALUE_DIM) : 1;
	localparam int MW     = (MODEL_DIM > 1) ? $clog2(MODEL_DIM) : 1;
	localparam int RW     = (KW > VW) ? KW : VW;
	localparam int OPW    = 25;
	localparam int PROD_W = 50;
	localparam int ACC_W  = 52;
	localparam int SC_W   = 40;
	localparam int D_W    = SC_W + 1;
	localparam int SUM_W  = 16 + SW;
	localparam int NUM_W  = 33;
	localparam int IW     = $clog2(EXP_TABLE_DEPTH);
	localparam int TBLW   = 16 * EXP_TABLE_DEPTH;

	// exp(-k/16) in Q0.16, from the recurrence e(k+1) = round(e(k) * r / 2^32)
	function automatic logic [TBLW-1:0] build_exp_tbl();
		logic [63:0]     e;
		logic [63:0]     t;
		logic [TBLW-1:0] tb;
		int              n;
		e  = 64'h1_0000_0000;
		tb = '0;
		for (n = 0; n < EXP_TABLE_DEPTH; n++) begin
			t = (e + 64'd32768) >> 16;
			tb[n*16 +: 16] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
			e = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
		end
		return tb;
	endfunction

	localparam logic [TBLW-1:0] EXP_TBL = build_exp_tbl();

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_PROJ  = 12'b0000_0000_0010,
		S_PWAIT = 12'b0000_0000_0100,
		S_SCORE = 12'b0000_0000_1000,
		S_SWAIT = 12'b0000_0001_0000,
		S_MAX   = 12'b0000_0010_0000,
		S_EXP   = 12'b0000_0100_0000,
		S_DINIT = 12'b0000_1000_0000,
		S_DIV   = 12'b0001_0000_0000,
		S_OUTM  = 12'b0010_0000_0000,
		S_OWAIT = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		DST_QUERY  = 3'd0,
		DST_KEY    = 3'd1,
		DST_VALUE  = 3'd2,
		DST_SCORE  = 3'd3,
		DST_RESULT = 3'd4
	} dst_t;

	typedef struct packed {
		logic          first;
		logic          fin;
		dst_t          dst;
		logic [SW-1:0] i0;
		logic [RW-1:0] i1;
	} tag_t;

	state_t state_q;

	// row stores
	logic [23:0] qrow_q [SEQ_LEN][KEY_DIM];
	logic [23:0] krow_q [SEQ_LEN][KEY_DIM];
	logic [23:0] vrow_q [SEQ_LEN][VALUE_DIM];
	logic [3:0][15:0] tok_q;

	// softmax working set
	logic signed [SC_W-1:0] score_q [SEQ_LEN];
	logic signed [SC_W-1:0] mx_q;
	logic [15:0]            ex_q [SEQ_LEN];
	logic [15:0]            wt_q [SEQ_LEN];
	logic [15:0]            res_q [VALUE_DIM];
	logic [SUM_W-1:0]       sum_q;

	// counters
	logic [SW-1:0]  tcnt_q;
	logic [SW-1:0]  qi_q;
	logic [SW-1:0]  j_q;
	logic [RW-1:0]  k_q;
	logic [1:0]     pmat_q;
	logic [RW-1:0]  prow_q;
	logic [MW-1:0]  pcol_q;
	logic [RAW-1:0] addr_q;

	// divider
	logic [NUM_W-1:0] num_q;
	logic [SUM_W-1:0] rem_q;
	logic [16:0]      quo_q;
	logic [5:0]       dcnt_q;
	logic [SUM_W:0]   div_r2;
	logic             div_ge;
	logic [SUM_W-1:0] div_rem_n;
	logic [16:0]      div_quo_n;

	// MAC pipeline
	logic                   issue;
	tag_t                   itag;
	logic signed [OPW-1:0]  opa_n;
	logic signed [OPW-1:0]  opb_n;
	logic                   v_s1;
	tag_t                   tag_s1;
	logic signed [OPW-1:0]  opa_s1;
	logic signed [OPW-1:0]  opb_s1;
	logic signed [OPW-1:0]  mul_a;
	logic                   v_s2;
	tag_t                   tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  accsum;
	logic signed [ACC_W-1:0]  sh12;
	logic signed [ACC_W-1:0]  sh16;
	logic [23:0]              sat24;
	logic [15:0]              sat16;

	// weight RAM
	logic        ram_we;
	logic [15:0] ram_rdata;

	// exp lookup
	logic [D_W-1:0]   exp_d;
	logic [D_W-9:0]   exp_idx;
	logic [15:0]      exp_val;

	// result register
	logic        rv_q;
	logic        out_load;
	logic [15:0] wsel [4];
	logic [15:0] rsel [3];
	logic [1:0]  qidx_q;
	logic [15:0] wout_q [4];
	logic [15:0] rout_q [3];
	logic        last_q;

	logic [RW-1:0] prow_last;

	assign cmd_stall = (state_q != S_IDLE);
	assign ram_we    = cmd_valid && !cmd_stall && (cmd.kind == CMD_WRITE);

	sa_ram #(
		.WIDTH (16),
		.DEPTH (NW)
	) u_wram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.waddr[RAW-1:0]),
		.wdata (cmd.wval),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign prow_last = (pmat_q == 2'd2) ? RW'(VALUE_DIM - 1) : RW'(KEY_DIM - 1);

	// issue stage
	always_comb begin
		issue = 1'b0;
		itag  = '0;
		opa_n = '0;
		opb_n = '0;
		case (state_q)
			S_PROJ: begin
				issue      = 1'b1;
				itag.first = (pcol_q == '0);
				itag.fin   = (pcol_q == MW'(MODEL_DIM - 1));
				itag.dst   = (pmat_q == 2'd0) ? DST_QUERY :
				             (pmat_q == 2'd1) ? DST_KEY : DST_VALUE;
				itag.i0    = tcnt_q;
				itag.i1    = prow_q;
				opb_n      = {{9{tok_q[pcol_q][15]}}, tok_q[pcol_q]};
			end
			S_SCORE: begin
				issue      = 1'b1;
				itag.first = (k_q == '0);
				itag.fin   = (k_q == RW'(KEY_DIM - 1));
				itag.dst   = DST_SCORE;
				itag.i0    = j_q;
				itag.i1    = k_q;
				opa_n      = {qrow_q[qi_q][k_q[KW-1:0]][23], qrow_q[qi_q][k_q[KW-1:0]]};
				opb_n      = {krow_q[j_q][k_q[KW-1:0]][23], krow_q[j_q][k_q[KW-1:0]]};
			end
			S_OUTM: begin
				issue      = 1'b1;
				itag.first = (j_q == '0);
				itag.fin   = (j_q == SW'(SEQ_LEN - 1));
				itag.dst   = DST_RESULT;
				itag.i0    = j_q;
				itag.i1    = k_q;
				opa_n      = {9'b0, wt_q[j_q]};
				opb_n      = {vrow_q[j_q][k_q[VW-1:0]][23], vrow_q[j_q][k_q[VW-1:0]]};
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// weight operand comes straight from the RAM read register
	assign mul_a = (tag_s1.dst == DST_QUERY || tag_s1.dst == DST_KEY ||
	                tag_s1.dst == DST_VALUE) ? {{9{ram_rdata[15]}}, ram_rdata} : opa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			v_s1   <= issue;
			tag_s1 <= itag;
			v_s2   <= v_s1;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		opa_s1  <= opa_n;
		opb_s1  <= opb_n;
		prod_s2 <= mul_a * opb_s1;
		if (v_s2) begin
			acc_q <= accsum;
		end
	end

	// accumulate and write back
	always_comb begin
		accsum = (tag_s2.first ? {ACC_W{1'b0}} : acc_q) + ACC_W'(prod_s2);
		sh12   = accsum >>> 12;
		sh16   = accsum >>> 16;
		if (sh12 > 52'sd8388607)
			sat24 = 24'h7F_FFFF;
		else if (sh12 < -52'sd8388608)
			sat24 = 24'h80_0000;
		else
			sat24 = sh12[23:0];
		if (sh16 > 52'sd32767)
			sat16 = 16'h7FFF;
		else if (sh16 < -52'sd32768)
			sat16 = 16'h8000;
		else
			sat16 = sh16[15:0];
	end

	always_ff @(posedge clk) begin
		if (v_s2 && tag_s2.fin) begin
			case (tag_s2.dst)
				DST_QUERY:  qrow_q[tag_s2.i0][tag_s2.i1[KW-1:0]] <= sat24;
				DST_KEY:    krow_q[tag_s2.i0][tag_s2.i1[KW-1:0]] <= sat24;
				DST_VALUE:  vrow_q[tag_s2.i0][tag_s2.i1[VW-1:0]] <= sat24;
				DST_SCORE:  score_q[tag_s2.i0] <= sh12[SC_W-1:0];
				DST_RESULT: res_q[tag_s2.i1[VW-1:0]] <= sat16;
				default: ;
			endcase
		end
	end

	// softmax helpers
	always_comb begin
		exp_d   = D_W'(mx_q) - D_W'(score_q[j_q]);
		exp_idx = exp_d[D_W-1:8];
		if (exp_idx < (D_W-8)'(EXP_TABLE_DEPTH))
			exp_val = EXP_TBL[{exp_idx[IW-1:0], 4'b0000} +: 16];
		else
			exp_val = 16'd0;
	end

	always_comb begin
		div_r2    = {rem_q, num_q[NUM_W-1]};
		div_ge    = div_r2 >= {1'b0, sum_q};
		div_rem_n = div_ge ? SUM_W'(div_r2 - {1'b0, sum_q}) : div_r2[SUM_W-1:0];
		div_quo_n = {quo_q[15:0], div_ge};
	end

	assign out_load = (state_q == S_EMIT) && (!rv_q || !result_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tcnt_q  <= '0;
			qi_q    <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pmat_q  <= '0;
			prow_q  <= '0;
			pcol_q  <= '0;
			addr_q  <= '0;
			dcnt_q  <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (out_load)
				rv_q <= 1'b1;
			else if (!result_stall)
				rv_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.kind == CMD_TOKEN) begin
						pmat_q  <= '0;
						prow_q  <= '0;
						pcol_q  <= '0;
						addr_q  <= '0;
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					addr_q <= addr_q + 1'b1;
					if (pcol_q == MW'(MODEL_DIM - 1)) begin
						pcol_q <= '0;
						if (prow_q == prow_last) begin
							prow_q <= '0;
							if (pmat_q == 2'd2)
								state_q <= S_PWAIT;
							else
								pmat_q <= pmat_q + 1'b1;
						end else begin
							prow_q <= prow_q + 1'b1;
						end
					end else begin
						pcol_q <= pcol_q + 1'b1;
					end
				end
				S_PWAIT: begin
					if (!v_s1 && !v_s2) begin
						if (tcnt_q == SW'(SEQ_LEN - 1)) begin
							tcnt_q  <= '0;
							qi_q    <= '0;
							j_q     <= '0;
							k_q     <= '0;
							state_q <= S_SCORE;
						end else begin
							tcnt_q  <= tcnt_q + 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SCORE: begin
					if (k_q == RW'(KEY_DIM - 1)) begin
						k_q <= '0;
						if (j_q == SW'(SEQ_LEN - 1)) begin
							j_q     <= '0;
							state_q <= S_SWAIT;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_SWAIT: begin
					if (!v_s1 && !v_s2) begin
						j_q     <= '0;
						state_q <= S_MAX;
					end
				end
				S_MAX: begin
					if (j_q == SW'(SEQ_LEN - 1)) begin
						j_q     <= '0;
						state_q <= S_EXP;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_EXP: begin
					if (j_q == SW'(SEQ_LEN - 1)) begin
						j_q     <= '0;
						state_q <= S_DINIT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DINIT: begin
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(NUM_W - 1)) begin
						if (j_q == SW'(SEQ_LEN - 1)) begin
							j_q     <= '0;
							k_q     <= '0;
							state_q <= S_OUTM;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_DINIT;
						end
					end
				end
				S_OUTM: begin
					if (j_q == SW'(SEQ_LEN - 1)) begin
						j_q <= '0;
						if (k_q == RW'(VALUE_DIM - 1)) begin
							k_q     <= '0;
							state_q <= S_OWAIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_OWAIT: begin
					if (!v_s1 && !v_s2)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						j_q <= '0;
						k_q <= '0;
						if (qi_q == SW'(SEQ_LEN - 1)) begin
							qi_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							qi_q    <= qi_q + 1'b1;
							state_q <= S_SCORE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.kind == CMD_TOKEN)
			tok_q <= cmd.tok;
		if (state_q == S_MAX && (j_q == '0 || score_q[j_q] > mx_q))
			mx_q <= score_q[j_q];
		if (state_q == S_EXP) begin
			ex_q[j_q] <= exp_val;
			sum_q     <= ((j_q == '0) ? {SUM_W{1'b0}} : sum_q) + SUM_W'(exp_val);
		end
		if (state_q == S_DINIT) begin
			num_q <= {1'b0, ex_q[j_q], 16'b0} + NUM_W'(sum_q >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == S_DIV) begin
			num_q <= num_q << 1;
			rem_q <= div_rem_n;
			quo_q <= div_quo_n;
			if (dcnt_q == 6'(NUM_W - 1))
				wt_q[j_q] <= div_quo_n[16] ? 16'hFFFF : div_quo_n[15:0];
		end
	end

	// result register
	for (genvar n = 0; n < 4; n++) begin : g_wsel
		if (n < SEQ_LEN) begin : g_on
			assign wsel[n] = wt_q[n];
		end else begin : g_off
			assign wsel[n] = 16'd0;
		end
	end
	for (genvar n = 0; n < 3; n++) begin : g_rsel
		if (n < VALUE_DIM) begin : g_on
			assign rsel[n] = res_q[n];
		end else begin : g_off
			assign rsel[n] = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			qidx_q <= 2'(qi_q);
			wout_q <= wsel;
			rout_q <= rsel;
			last_q <= (qi_q == SW'(SEQ_LEN - 1));
		end
	end

	assign result_valid = rv_q;
	assign query_index  = qidx_q;
	assign weight_0     = wout_q[0];
	assign weight_1     = wout_q[1];
	assign weight_2     = wout_q[2];
	assign weight_3     = wout_q[3];
	assign result_0     = rout_q[0];
	assign result_1     = rout_q[1];
	assign result_2     = rout_q[2];
	assign last         = last_q;

	// no MAC work in flight while the engine takes commands
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2))
		else $error("MAC pipeline busy in idle");

	// restoring divider keeps its remainder below the softmax sum
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < sum_q))
		else $error("divider remainder out of range");

	// a new result only appears after the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rv_q) |-> $past(state_q == S_EMIT))
		else $error("result valid raised outside emit");

	// weight writes only land between tokens
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE && !v_s1))
		else $error("weight write during projection");
endmodule
`default_nettype wire

@@ rtl/self_attention_head.sv @@
// Top level of the single-head self-attention block: front end, command
// queue and engine. Depends on sa_pkg, sa_front, sa_queue, sa_engine.
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   op, weight_*, token_elem_0..3
//   result    result_valid / result_stall  query_index, weight_0..3,
//                                       result_0..2, last
//
// The engine takes a weight write directly in its idle state. A token runs one
// MAC issue per projection weight on the one shared multiplier, then drains
// the pipeline. The token that closes the sequence then runs, per query row,
// the score, max, exp, divide and output steps; the 33-step restoring
// divider in the softmax dominates.
// Reset (arst_n low) clears control only; stores are undefined until written.
// The two-entry queue keeps taking transactions while the engine is busy,
// until both entries are full, and the result register holds a stalled
// transaction while the next row is computed.
`default_nettype none
module self_attention_head #(
	parameter int SEQ_LEN         = 4,
	parameter int MODEL_DIM       = 4,
	parameter int KEY_DIM         = 3,
	parameter int VALUE_DIM       = 3,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               op,
	input  wire logic [1:0]         weight_matrix,
	input  wire logic [2:0]         weight_row,
	input  wire logic [1:0]         weight_col,
	input  wire logic signed [15:0] weight_value,
	input  wire logic signed [15:0] token_elem_0,
	input  wire logic signed [15:0] token_elem_1,
	input  wire logic signed [15:0] token_elem_2,
	input  wire logic signed [15:0] token_elem_3,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              query_index,
	output logic [15:0]             weight_0,
	output logic [15:0]             weight_1,
	output logic [15:0]             weight_2,
	output logic [15:0]             weight_3,
	output logic signed [15:0]      result_0,
	output logic signed [15:0]      result_1,
	output logic signed [15:0]      result_2,
	output logic                    last
);
	import sa_pkg::*;

	// front end -> queue
	logic push_valid;
	logic push_stall;
	cmd_t push_cmd;

	// queue -> engine
	logic pop_valid;
	logic pop_stall;
	cmd_t pop_cmd;

	sa_front #(
		.MODEL_DIM (MODEL_DIM),
		.KEY_DIM   (KEY_DIM),
		.VALUE_DIM (VALUE_DIM)
	) u_front (
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.weight_matrix (weight_matrix),
		.weight_row    (weight_row),
		.weight_col    (weight_col),
		.weight_value  (weight_value),
		.token_elem_0  (token_elem_0),
		.token_elem_1  (token_elem_1),
		.token_elem_2  (token_elem_2),
		.token_elem_3  (token_elem_3),
		.push_valid    (push_valid),
		.push_stall    (push_stall),
		.push_cmd      (push_cmd)
	);

	sa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_cmd    (pop_cmd)
	);

	sa_engine #(
		.SEQ_LEN         (SEQ_LEN),
		.MODEL_DIM       (MODEL_DIM),
		.KEY_DIM         (KEY_DIM),
		.VALUE_DIM       (VALUE_DIM),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (pop_valid),
		.cmd_stall    (pop_stall),
		.cmd          (pop_cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.query_index  (query_index),
		.weight_0     (weight_0),
		.weight_1     (weight_1),
		.weight_2     (weight_2),
		.weight_3     (weight_3),
		.result_0     (result_0),
		.result_1     (result_1),
		.result_2     (result_2),
		.last         (last)
	);
endmodule
`default_nettype wire

@@ test/tb_self_attention_head.sv @@
// Testbench for self_attention_head: drives weight writes and token transactions,
// predicts each attention row in-bench and compares every result field.
// Depends on sa_pkg and the self_attention_head RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_self_attention_head;
	import sa_pkg::*;

	localparam int SEQ = 4, MDIM = 4, KDIM = 3, VDIM = 3, EXP_DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  qidx;
		logic [3:0][15:0] wts;
		logic [2:0][15:0] outs;
		logic        lst;
	} attn_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_WEIGHT;
	logic [1:0] weight_matrix = MAT_QUERY;
	logic [2:0] weight_row = '0;
	logic [1:0] weight_col = '0;
	logic signed [15:0] weight_value = '0;
	logic signed [15:0] token_elem_0 = '0, token_elem_1 = '0;
	logic signed [15:0] token_elem_2 = '0, token_elem_3 = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] query_index;
	logic [15:0] weight_0, weight_1, weight_2, weight_3;
	logic signed [15:0] result_0, result_1, result_2;
	logic last;

	self_attention_head dut (.*);

	always #5 clk = ~clk;

	// predictor state
	longint proj_w [0:2*KDIM+VDIM-1][0:MDIM-1];
	longint q_rows [0:SEQ-1][0:KDIM-1];
	longint k_rows [0:SEQ-1][0:KDIM-1];
	longint v_rows [0:SEQ-1][0:VDIM-1];
	int unsigned tok_pos;
	longint unsigned exp_lut [0:EXP_DEPTH-1];
	attn_row_t pending_rows[$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit quiet_tail = 0;  // no random idle bursts on either side in the final part

	// clamp to [lo, hi]; floor division by 2^s on signed values is done with >>>, which floors
	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void build_exp_lut();
		longint unsigned e, t;
		e = 64'd1 << 32;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			t = (e + 32768) >> 16;
			exp_lut[k] = t > 65535 ? 65535 : t;
			e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
		end
	endfunction

	function automatic longint project_row(int r, longint tv[4]);
		longint acc = 0;
		for (int j = 0; j < MDIM; j++) acc += proj_w[r][j] * tv[j];
		return sat(acc >>> 12, -8388608, 8388607);
	endfunction

	function automatic attn_row_t attend_query(int q);
		attn_row_t row;
		longint sc[SEQ];
		longint unsigned ex[SEQ], wt[SEQ], sum, idx, w;
		longint mx, acc;
		row = '0;
		sum = 0;
		for (int j = 0; j < SEQ; j++) begin
			acc = 0;
			for (int k = 0; k < KDIM; k++) acc += q_rows[q][k] * k_rows[j][k];
			sc[j] = acc >>> 12;
		end
		mx = sc[0];
		for (int j = 1; j < SEQ; j++) if (sc[j] > mx) mx = sc[j];
		for (int j = 0; j < SEQ; j++) begin
			idx = longint'(mx - sc[j]) >> 8;
			ex[j] = idx < EXP_DEPTH ? exp_lut[idx] : 0;
			sum += ex[j];
		end
		if (sum == 0) sum = 1;
		for (int j = 0; j < SEQ; j++) begin
			w = (ex[j] * 65536 + sum / 2) / sum;
			wt[j] = w > 65535 ? 65535 : w;
			row.wts[j] = wt[j][15:0];
		end
		for (int k = 0; k < VDIM; k++) begin
			acc = 0;
			for (int j = 0; j < SEQ; j++) acc += longint'(wt[j]) * v_rows[j][k];
			row.outs[k] = 16'(sat(acc >>> 16, -32768, 32767));
		end
		row.qidx = 2'(q);
		row.lst = (q == SEQ - 1);
		return row;
	endfunction

	// apply one accepted transaction to the predictor
	function automatic void predict_item(logic o, logic [1:0] m, logic [2:0] r,
			logic [1:0] c, logic signed [15:0] wv, logic signed [15:0] t0,
			logic signed [15:0] t1, logic signed [15:0] t2, logic signed [15:0] t3);
		longint tv[4];
		if (o == OP_WEIGHT) begin
			// bad matrix or row beyond the matrix is dropped
			if (m == MAT_QUERY && r < KDIM) proj_w[r][c] = wv;
			else if (m == MAT_KEY && r < KDIM) proj_w[KDIM + r][c] = wv;
			else if (m == MAT_VALUE && r < VDIM) proj_w[2*KDIM + r][c] = wv;
			return;
		end
		tv[0] = t0; tv[1] = t1; tv[2] = t2; tv[3] = t3;
		for (int k = 0; k < KDIM; k++) begin
			q_rows[tok_pos][k] = project_row(k, tv);
			k_rows[tok_pos][k] = project_row(KDIM + k, tv);
		end
		for (int k = 0; k < VDIM; k++) v_rows[tok_pos][k] = project_row(2*KDIM + k, tv);
		tok_pos++;
		if (tok_pos == SEQ) begin
			tok_pos = 0;
			for (int q = 0; q < SEQ; q++) pending_rows.push_back(attend_query(q));
		end
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 19)) @(posedge clk);
	endtask

	// one transaction on the item channel; valid stays high across back-to-back sends
	task automatic send_item(logic o, logic [1:0] m, logic [2:0] r, logic [1:0] c,
			logic signed [15:0] wv, logic signed [15:0] t0, logic signed [15:0] t1,
			logic signed [15:0] t2, logic signed [15:0] t3);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			idle_burst();
		end
		item_valid <= 1'b1;
		op <= o; weight_matrix <= m; weight_row <= r; weight_col <= c;
		weight_value <= wv;
		token_elem_0 <= t0; token_elem_1 <= t1; token_elem_2 <= t2; token_elem_3 <= t3;
		do @(posedge clk); while (item_stall);
		predict_item(o, m, r, c, wv, t0, t1, t2, t3);
	endtask

	task automatic go_idle();
		item_valid <= 1'b0;
	endtask

	task automatic write_weight(logic [1:0] m, logic [2:0] r, logic [1:0] c,
			logic signed [15:0] wv);
		send_item(OP_WEIGHT, m, r, c, wv, 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic send_token(logic signed [15:0] t0, logic signed [15:0] t1,
			logic signed [15:0] t2, logic signed [15:0] t3);
		send_item(OP_TOKEN, 2'($urandom), 3'($urandom), 2'($urandom), 16'($urandom),
			t0, t1, t2, t3);
	endtask

	// fill all valid weight slots; mode 0 small random, 1 max, 2 min, 3 full random
	task automatic load_weights(int mode);
		logic signed [15:0] wv;
		for (int mt = 0; mt < 3; mt++)
			for (int r = 0; r < (mt == 2 ? VDIM : KDIM); r++)
				for (int c = 0; c < MDIM; c++) begin
					case (mode)
						0: wv = 16'($signed($urandom_range(0, 8191)) - 4096);
						1: wv = 16'sh7fff;
						2: wv = 16'sh8000;
						default: wv = 16'($urandom);
					endcase
					write_weight(2'(mt), 3'(r), 2'(c), wv);
				end
	endtask

	task automatic drain_results();
		go_idle();
		while (pending_rows.size() != 0 && !timed_out) @(posedge clk);
	endtask

	task automatic test_reset_and_extremes();
		load_weights(0);
		send_token(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_token(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_token(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		send_token(16'sh1000, 16'shf000, 16'sh7fff, 16'sh8000);
		drain_results();
	endtask

	task automatic test_saturation();
		load_weights(1);
		repeat (SEQ) send_token(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
		load_weights(2);
		repeat (SEQ) send_token(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
		drain_results();
	endtask

	// bad matrix code, out-of-range rows, and a weight change mid-sequence
	task automatic test_bad_addr_and_midseq();
		write_weight(2'd3, 3'd0, 2'd0, 16'sh7fff);
		write_weight(MAT_QUERY, 3'd7, 2'd3, 16'sh8000);
		write_weight(MAT_KEY, 3'(KDIM), 2'd1, 16'sh1234);
		write_weight(MAT_VALUE, 3'(VDIM), 2'd2, 16'sh4321);
		send_token(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		write_weight(MAT_VALUE, 3'd1, 2'd2, 16'sh7000);
		send_token(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		write_weight(MAT_QUERY, 3'd0, 2'd0, 16'sh9000);
		send_token(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		send_token(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		drain_results();
	endtask

	// mostly tokens with random content, with stray writes as noise
	task automatic test_random_traffic(int n_items);
		int sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				write_weight(2'($urandom), 3'($urandom), 2'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(0, 1))
					send_token(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				else
					send_token(16'($signed($urandom_range(0, 16383)) - 8192),
						16'($signed($urandom_range(0, 16383)) - 8192),
						16'($signed($urandom_range(0, 16383)) - 8192),
						16'($signed($urandom_range(0, 16383)) - 8192));
			end
			sent++;
			// sender holds off until every row has arrived
			if (sent == n_items / 2) drain_results();
		end
	endtask

	// result stall: random bursts, none in the tail
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				idle_burst();
				result_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		attn_row_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got.qidx = query_index;
			got.wts = {weight_3, weight_2, weight_1, weight_0};
			got.outs = {result_2, result_1, result_0};
			got.lst = last;
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %h", got);
			end else begin
				want = pending_rows.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		build_exp_lut();
		tok_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_extremes();
		test_saturation();
		test_bad_addr_and_midseq();
		test_random_traffic(24);
		quiet_tail = 1;
		test_random_traffic(16);
		drain_results();
		repeat (600) @(posedge clk);
		if (mismatches == 0 && pending_rows.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
